@@ src/jts_pkg.sv @@
// Shared types, constants and helpers for the JSON token scanner.
package jts_pkg;

  localparam int unsigned MAX_DEPTH = 31;
  localparam int unsigned POS_W     = 24;
  localparam int unsigned DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ARR_W     = MAX_DEPTH + 1;
  localparam int unsigned IDX_W     = $clog2(ARR_W);
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned TOK_W     = 24;
  localparam int unsigned FIN_W     = 26;
  localparam int unsigned SKIP_W    = 3;
  localparam int unsigned NREC      = 3;
  localparam int unsigned CNT_W     = 2;

  localparam logic [KIND_W-1:0] K_KEY    = 4'd0;
  localparam logic [KIND_W-1:0] K_STR    = 4'd1;
  localparam logic [KIND_W-1:0] K_NUM    = 4'd2;
  localparam logic [KIND_W-1:0] K_OOPEN  = 4'd3;
  localparam logic [KIND_W-1:0] K_OCLOSE = 4'd4;
  localparam logic [KIND_W-1:0] K_AOPEN  = 4'd5;
  localparam logic [KIND_W-1:0] K_ACLOSE = 4'd6;
  localparam logic [KIND_W-1:0] K_FALSE  = 4'd7;
  localparam logic [KIND_W-1:0] K_NULL   = 4'd8;
  localparam logic [KIND_W-1:0] K_TRUE   = 4'd9;
  localparam logic [KIND_W-1:0] K_DONE   = 4'd10;
  localparam logic [KIND_W-1:0] K_ENDED  = 4'd11;
  localparam logic [KIND_W-1:0] K_BAD    = 4'd12;
  localparam logic [KIND_W-1:0] K_OVER   = 4'd13;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [SKIP_W-1:0] SKIP_FALSE = 3'd4;
  localparam logic [SKIP_W-1:0] SKIP_NT    = 3'd3;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_SKIP = 2'd3
  } mode_e;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    mode_e              mode;
    logic [DEPTH_W-1:0] depth;
    logic [ARR_W-1:0]   is_arr;
    logic               expect_key;
    logic               bs_par;
    logic [POS_W-1:0]   tok_begin;
    logic [SKIP_W-1:0]  skip_left;
    logic [FIN_W-1:0]   words;
  } scan_st_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TOK_W-1:0]  start;
    logic [TOK_W-1:0]  len;
    logic [FIN_W-1:0]  fin;
  } rec_t;

  function automatic rec_t mk_rec(logic [KIND_W-1:0] kind, logic [POS_W-1:0] start,
                                  logic [POS_W-1:0] len, logic [FIN_W-1:0] fin);
    rec_t r;
    r.kind  = kind;
    r.start = TOK_W'(start);
    r.len   = TOK_W'(len);
    r.fin   = fin;
    return r;
  endfunction

  // Saturating word counter bump
  function automatic logic [FIN_W-1:0] words_add(logic [FIN_W-1:0] w, logic [1:0] add);
    logic [FIN_W:0] sum;
    sum = {1'b0, w} + {{(FIN_W - 1){1'b0}}, add};
    return sum[FIN_W] ? {FIN_W{1'b1}} : sum[FIN_W-1:0];
  endfunction

  function automatic logic is_num_byte(logic [7:0] b);
    return (b >= CH_ZERO && b <= CH_NINE) || b == CH_PLUS || b == CH_MINUS ||
           b == CH_DOT || b == CH_LOW_E || b == CH_UP_E;
  endfunction

endpackage

@@ src/json_token_scanner_unit.sv @@
// The records of an accepted byte are registered and the first shows on the next cycle.
// Throughput: one byte per cycle while each byte yields at most one record and the output
// is not stalled; a byte yielding n records holds the record register for n output transfers.
// The scan state is computed combinationally from the input byte and registered on accept.
// Reset: asynchronous, clears scan state and drops any pending records.
// Top level of the streaming JSON token scanner.
module json_token_scanner_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   in_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [jts_pkg::KIND_W-1:0]   record_kind_o,
  output logic [jts_pkg::TOK_W-1:0]    token_start_o,
  output logic [jts_pkg::TOK_W-1:0]    token_length_o,
  output logic [jts_pkg::FIN_W-1:0]    final_value_o,
  output logic                         run_last_o
);
  import jts_pkg::*;

  scan_st_t         st_q, st_d;
  rec_t [NREC-1:0]  recs;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  rec_t             rec;

  assign accept = in_valid_i && in_ready_o;

  jts_step u_step (
    .st_i   (st_q),
    .byte_i (in_byte_i),
    .st_o   (st_d),
    .recs_o (recs),
    .cnt_o  (cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  jts_rec_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .recs_i      (recs),
    .cnt_i       (cnt),
    .free_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec),
    .last_o      (run_last_o)
  );

  assign record_kind_o  = rec.kind;
  assign token_start_o  = rec.start;
  assign token_length_o = rec.len;
  assign final_value_o  = rec.fin;

endmodule

@@ src/jts_step.sv @@
// Next-state and record generation for one document byte.
module jts_step (
  input  jts_pkg::scan_st_t           st_i,
  input  logic [7:0]                  byte_i,
  output jts_pkg::scan_st_t           st_o,
  output jts_pkg::rec_t [jts_pkg::NREC-1:0] recs_o,
  output logic [jts_pkg::CNT_W-1:0]   cnt_o
);
  import jts_pkg::*;

  scan_st_t            st;
  rec_t [NREC-1:0]     recs;
  logic [CNT_W-1:0]    n;
  logic                doc_over;
  logic                fresh;
  logic [POS_W-1:0]    at;
  logic [IDX_W-1:0]    lvl;

  always_comb begin
    st       = st_i;
    recs     = '0;
    n        = '0;
    doc_over = 1'b0;
    fresh    = 1'b0;
    lvl      = '0;
    at       = st_i.pos;
    st.pos   = at + POS_W'(1);

    case (st_i.mode)
      MODE_STR: begin
        if (byte_i == CH_NUL) begin
          recs[n] = mk_rec(K_ENDED, '0, '0, FIN_W'(at));
          n = n + 2'd1;
          doc_over = 1'b1;
        end else if (byte_i == CH_QUOTE && !st_i.bs_par) begin
          recs[n] = mk_rec(st.expect_key ? K_KEY : K_STR, st.tok_begin,
                           at - st.tok_begin, '0);
          n = n + 2'd1;
          st.words = words_add(st.words, 2'd3);
          st.expect_key = 1'b0;
          st.mode = MODE_IDLE;
          if (st.depth == '0) begin
            recs[n] = mk_rec(K_DONE, '0, '0, st.words);
            n = n + 2'd1;
            doc_over = 1'b1;
          end
        end else begin
          st.bs_par = (byte_i == CH_BSLASH) ? ~st_i.bs_par : 1'b0;
        end
      end
      MODE_NUM: begin
        if (!is_num_byte(byte_i)) begin
          recs[n] = mk_rec(K_NUM, st.tok_begin, at - st.tok_begin, '0);
          n = n + 2'd1;
          st.words = words_add(st.words, 2'd3);
          st.mode = MODE_IDLE;
          // at the top level the terminating byte is dropped
          if (st.depth == '0) begin
            recs[n] = mk_rec(K_DONE, '0, '0, st.words);
            n = n + 2'd1;
            doc_over = 1'b1;
          end else begin
            fresh = 1'b1;
          end
        end
      end
      MODE_SKIP: begin
        if (byte_i == CH_NUL) begin
          recs[n] = mk_rec(K_ENDED, '0, '0, FIN_W'(at));
          n = n + 2'd1;
          doc_over = 1'b1;
        end else begin
          if (st.skip_left != '0) st.skip_left = st.skip_left - SKIP_W'(1);
          if (st.skip_left == '0) st.mode = MODE_IDLE;
        end
      end
      default: fresh = 1'b1;
    endcase

    if (fresh) begin
      lvl = st.depth[IDX_W-1:0];
      case (byte_i)
        CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_COLON: ;
        CH_NUL: begin
          recs[n] = mk_rec(K_ENDED, '0, '0, FIN_W'(at));
          n = n + 2'd1;
          doc_over = 1'b1;
        end
        CH_QUOTE: begin
          st.tok_begin = at + POS_W'(1);
          st.bs_par = 1'b0;
          st.mode = MODE_STR;
        end
        CH_COMMA: begin
          st.expect_key = ~st.is_arr[lvl];
          if (st.depth == '0) begin
            recs[n] = mk_rec(K_DONE, '0, '0, st.words);
            n = n + 2'd1;
            doc_over = 1'b1;
          end
        end
        CH_LBRACE, CH_LBRACK: begin
          if (st.depth >= DEPTH_W'(MAX_DEPTH)) begin
            recs[n] = mk_rec(K_OVER, '0, '0, '0);
            n = n + 2'd1;
            doc_over = 1'b1;
          end else begin
            st.depth = st.depth + DEPTH_W'(1);
            lvl = st.depth[IDX_W-1:0];
            if (byte_i == CH_LBRACK) begin
              st.is_arr[lvl] = 1'b1;
              recs[n] = mk_rec(K_AOPEN, '0, '0, '0);
            end else begin
              st.is_arr[lvl] = 1'b0;
              st.expect_key = 1'b1;
              recs[n] = mk_rec(K_OOPEN, '0, '0, '0);
            end
            n = n + 2'd1;
            st.words = words_add(st.words, 2'd1);
          end
        end
        CH_RBRACE, CH_RBRACK: begin
          if (st.depth == '0) begin
            recs[n] = mk_rec(K_BAD, '0, '0, '0);
            n = n + 2'd1;
            doc_over = 1'b1;
          end else begin
            st.depth = st.depth - DEPTH_W'(1);
            recs[n] = mk_rec((byte_i == CH_RBRACE) ? K_OCLOSE : K_ACLOSE, '0, '0, '0);
            n = n + 2'd1;
            st.words = words_add(st.words, 2'd1);
            if (st.depth == '0) begin
              recs[n] = mk_rec(K_DONE, '0, '0, st.words);
              n = n + 2'd1;
              doc_over = 1'b1;
            end
          end
        end
        CH_F, CH_N, CH_T: begin
          recs[n] = mk_rec((byte_i == CH_F) ? K_FALSE : ((byte_i == CH_N) ? K_NULL : K_TRUE),
                           '0, '0, '0);
          n = n + 2'd1;
          st.words = words_add(st.words, 2'd1);
          if (st.depth == '0) begin
            recs[n] = mk_rec(K_DONE, '0, '0, st.words);
            n = n + 2'd1;
            doc_over = 1'b1;
          end else begin
            st.mode = MODE_SKIP;
            st.skip_left = (byte_i == CH_F) ? SKIP_FALSE : SKIP_NT;
          end
        end
        default: begin
          if (byte_i == CH_MINUS || (byte_i >= CH_ZERO && byte_i <= CH_NINE)) begin
            st.tok_begin = at;
            st.mode = MODE_NUM;
          end else begin
            recs[n] = mk_rec(K_BAD, '0, '0, '0);
            n = n + 2'd1;
            doc_over = 1'b1;
          end
        end
      endcase
    end

    // any final record starts a new document
    if (doc_over) st = '0;
  end

  assign st_o   = st;
  assign recs_o = recs;
  assign cnt_o  = n;

endmodule

@@ src/jts_rec_buf.sv @@
// Result register holding the records of one byte, drained one per transfer.
module jts_rec_buf (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  jts_pkg::rec_t [jts_pkg::NREC-1:0] recs_i,
  input  logic [jts_pkg::CNT_W-1:0]        cnt_i,
  output logic                             free_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output jts_pkg::rec_t                    rec_o,
  output logic                             last_o
);
  import jts_pkg::*;

  rec_t [NREC-1:0]  recs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  // free when empty, or when the last record leaves in this cycle
  assign free_o      = (cnt_q == '0) || (cnt_q == CNT_W'(1) && out_ready_i);
  assign rec_o       = recs_q[rd_q];
  assign last_o      = (cnt_q == CNT_W'(1));

  always_comb begin
    cnt_d = cnt_q;
    rd_d  = rd_q;
    if (pop) begin
      cnt_d = cnt_q - CNT_W'(1);
      rd_d  = rd_q + CNT_W'(1);
    end
    if (load_i) begin
      cnt_d = cnt_i;
      rd_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) recs_q <= recs_i;
  end

endmodule

@@ src/jts_checker.sv @@
// Port-level checks for the JSON token scanner, bound to the top level.
module jts_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [7:0]                 in_byte_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [jts_pkg::KIND_W-1:0] record_kind_o,
  input logic [jts_pkg::TOK_W-1:0]  token_start_o,
  input logic [jts_pkg::TOK_W-1:0]  token_length_o,
  input logic [jts_pkg::FIN_W-1:0]  final_value_o,
  input logic                       run_last_o
);
  import jts_pkg::*;

  // a waiting byte holds until its transfer
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_byte_i))
    else $error("input byte changed while waiting");

  // a stalled record holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(record_kind_o) &&
    $stable(final_value_o) && $stable(token_start_o))
    else $error("record changed while stalled");

  // a final record always closes the run for its byte
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == K_DONE || record_kind_o == K_ENDED ||
    record_kind_o == K_BAD || record_kind_o == K_OVER) |-> run_last_o)
    else $error("final record not last");

  // records other than keys, strings and numbers carry no text span
  a_no_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o != K_KEY && record_kind_o != K_STR &&
    record_kind_o != K_NUM |-> token_start_o == '0 && token_length_o == '0)
    else $error("span on non-text record");

  // more records of the same byte follow at once
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
    else $error("record run broken");

endmodule

bind json_token_scanner_unit jts_checker u_jts_checker (.*);
